[hdl/tlvdf_pkg.sv]
package tlvdf_pkg;

    // Command codes with a decoded layout
    localparam logic [7:0] CMD_RECEIVE_FRAME = 8'h85;
    localparam logic [7:0] CMD_FIRMWARE      = 8'h81;

    // Record layout: command, length, sequence low, sequence high, then payload
    localparam logic [8:0] POS_COMMAND  = 9'd0;
    localparam logic [8:0] POS_LENGTH   = 9'd1;
    localparam logic [8:0] POS_SEQ_LOW  = 9'd2;
    localparam logic [8:0] POS_SEQ_HIGH = 9'd3;
    localparam logic [8:0] HEADER_BYTES = 9'd4;

    // Payload offsets of the receive-frame fields
    localparam logic [8:0] OFS_ID    = 9'd4;
    localparam logic [8:0] OFS_DLC   = 9'd8;
    localparam logic [8:0] OFS_DATA  = 9'd9;
    localparam logic [8:0] OFS_END   = 9'd17;
    localparam logic [8:0] POS_LIMIT = 9'd258;

    localparam logic [7:0] MAX_DATA_BYTES = 8'd8;

    // Division by one thousand: quotient = (x * DIV_MAGIC) >> DIV_SHIFT, exact for 32 bits
    localparam int          PROD_W        = 61;
    localparam int          DIV_SHIFT     = 38;
    localparam logic [28:0] DIV_MAGIC     = 29'd274877907;
    localparam logic [31:0] MS_PER_SECOND = 32'd1000;
    localparam logic [19:0] US_PER_MS     = 20'd1000;

    typedef enum logic [1:0] {
        KIND_FRAME     = 2'd0,
        KIND_FRAME_ERR = 2'd1,
        KIND_FIRMWARE  = 2'd2,
        KIND_OTHER     = 2'd3
    } kind_t;

    // One completed record as handed from parser to decoder
    typedef struct packed {
        logic [7:0]  command;
        logic [15:0] sequence_no;
        logic [31:0] stamp;
        logic [31:0] frame_id;
        logic [7:0]  dlc;
        logic [63:0] data;
        logic        wait_match;
    } rec_t;

endpackage

[hdl/tlvdf_front.sv]
module tlvdf_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              byte_accept,
    input  logic [7:0]        rx_byte,
    input  logic              end_of_transfer,
    input  logic              cfg_write_en,
    input  logic [7:0]        cfg_write_data,
    output logic              push,
    output tlvdf_pkg::rec_t   push_rec
);
    import tlvdf_pkg::*;

    logic [8:0]  pos_reg, pos_next;
    logic [7:0]  wait_cmd_reg;
    logic [7:0]  cmd_reg, cmd_next;
    logic [7:0]  len_reg, len_next;
    logic [15:0] seq_reg, seq_next;
    logic [31:0] stamp_reg, stamp_next;
    logic [31:0] id_reg, id_next;
    logic [7:0]  dlc_reg, dlc_next;
    logic [63:0] data_reg, data_next;
    logic [8:0]  ofs;
    logic [8:0]  data_ofs;
    logic        complete;

    // Parse one byte of the transfer
    always_comb begin
        pos_next   = pos_reg;
        cmd_next   = cmd_reg;
        len_next   = len_reg;
        seq_next   = seq_reg;
        stamp_next = stamp_reg;
        id_next    = id_reg;
        dlc_next   = dlc_reg;
        data_next  = data_reg;
        push       = 1'b0;
        ofs        = pos_reg - HEADER_BYTES;
        data_ofs   = ofs - OFS_DATA;
        complete   = (pos_reg >= POS_SEQ_HIGH) && (pos_reg == POS_SEQ_HIGH + {1'b0, len_reg});
        if (byte_accept) begin
            priority if (pos_reg == POS_COMMAND) begin
                if (rx_byte != 8'd0) begin
                    cmd_next   = rx_byte;
                    len_next   = 8'd0;
                    seq_next   = 16'd0;
                    stamp_next = 32'd0;
                    id_next    = 32'd0;
                    dlc_next   = 8'd0;
                    data_next  = 64'd0;
                end
            end else if (pos_reg == POS_LENGTH) begin
                len_next = rx_byte;
            end else if (pos_reg == POS_SEQ_LOW) begin
                seq_next = {8'd0, rx_byte};
            end else if (pos_reg == POS_SEQ_HIGH) begin
                seq_next[15:8] = rx_byte;
            end else begin
                priority if (ofs < OFS_ID) begin
                    stamp_next[{ofs[1:0], 3'b000} +: 8] = rx_byte;
                end else if (ofs < OFS_DLC) begin
                    id_next[{ofs[1:0], 3'b000} +: 8] = rx_byte;
                end else if (ofs == OFS_DLC) begin
                    dlc_next = rx_byte;
                end else if (ofs < OFS_END) begin
                    data_next[{data_ofs[2:0], 3'b000} +: 8] = rx_byte;
                end else begin
                    // drop bytes beyond the frame data
                end
            end

            // Advance the position, skipping filler at the boundary
            priority if (pos_reg == POS_COMMAND && rx_byte == 8'd0) begin
                pos_next = POS_COMMAND;
            end else if (complete) begin
                pos_next = POS_COMMAND;
                push     = 1'b1;
            end else if (end_of_transfer) begin
                pos_next = POS_COMMAND;
            end else begin
                pos_next = pos_reg + 9'd1;
            end
        end
    end

    // Hand the finished record to the queue
    always_comb begin
        push_rec.command     = cmd_next;
        push_rec.sequence_no = seq_next;
        push_rec.stamp       = stamp_next;
        push_rec.frame_id    = id_next;
        push_rec.dlc         = dlc_next;
        push_rec.data        = data_next;
        push_rec.wait_match  = (cmd_next == wait_cmd_reg);
    end

    // Hold control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg      <= POS_COMMAND;
            wait_cmd_reg <= 8'd0;
        end else begin
            pos_reg <= pos_next;
            if (cfg_write_en) begin
                wait_cmd_reg <= cfg_write_data;
            end
        end
    end

    // Hold record fields
    always_ff @(posedge aclk) begin
        cmd_reg   <= cmd_next;
        len_reg   <= len_next;
        seq_reg   <= seq_next;
        stamp_reg <= stamp_next;
        id_reg    <= id_next;
        dlc_reg   <= dlc_next;
        data_reg  <= data_next;
    end

`ifndef SYNTHESIS
    // Position never runs past the longest record
    assert property (@(posedge aclk) disable iff (!aresetn) pos_reg <= POS_LIMIT)
        else $error("record position out of range");
    // A completed record always restarts at the boundary
    assert property (@(posedge aclk) disable iff (!aresetn) push |=> pos_reg == POS_COMMAND)
        else $error("position not cleared after record");
`endif

endmodule

[hdl/tlvdf_queue.sv]
module tlvdf_queue #(
    parameter int DEPTH = 4
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  tlvdf_pkg::rec_t   push_rec,
    input  logic              pop,
    output logic              full,
    output logic              not_empty,
    output tlvdf_pkg::rec_t   head_rec
);
    import tlvdf_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    rec_t          slot_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign full      = (count_reg == FULL_CNT);
    assign not_empty = (count_reg != '0);
    assign head_rec  = slot_reg[rd_ptr_reg];

    // Advance pointers and fill count
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PW'(1);
        end
        unique case ({push, pop})
            2'b10:   count_next = count_reg + CW'(1);
            2'b01:   count_next = count_reg - CW'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed record
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_rec;
        end
    end

`ifndef SYNTHESIS
    assert property (@(posedge aclk) disable iff (!aresetn) push |-> !full)
        else $error("push into full queue");
    assert property (@(posedge aclk) disable iff (!aresetn) pop |-> not_empty)
        else $error("pop from empty queue");
`endif

endmodule

[hdl/tlvdf_back.sv]
module tlvdf_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              rec_valid,
    input  tlvdf_pkg::rec_t   rec,
    output logic              pop,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [1:0]        m_record_kind,
    output logic [7:0]        m_command,
    output logic [15:0]       m_sequence_res,
    output logic [31:0]       m_can_id,
    output logic [3:0]        m_data_length,
    output logic [63:0]       m_payload,
    output logic [22:0]       m_stamp_seconds,
    output logic [19:0]       m_stamp_microseconds,
    output logic              m_wait_match
);
    import tlvdf_pkg::*;

    logic        advance;

    // Decode stage
    kind_t       kind;
    logic [31:0] id_dec;
    logic [3:0]  len_dec;
    logic [63:0] data_dec;

    logic               s1_valid_reg;
    kind_t              s1_kind_reg;
    logic [7:0]         s1_cmd_reg;
    logic [15:0]        s1_seq_reg;
    logic [31:0]        s1_id_reg;
    logic [3:0]         s1_len_reg;
    logic [63:0]        s1_data_reg;
    logic               s1_match_reg;
    logic [31:0]        s1_stamp_reg;
    logic [PROD_W-1:0]  s1_prod_reg;

    // Remainder stage
    logic [22:0] quot;
    logic [31:0] quot_ms;
    logic [31:0] rem_wide;

    logic        s2_valid_reg;
    kind_t       s2_kind_reg;
    logic [7:0]  s2_cmd_reg;
    logic [15:0] s2_seq_reg;
    logic [31:0] s2_id_reg;
    logic [3:0]  s2_len_reg;
    logic [63:0] s2_data_reg;
    logic        s2_match_reg;
    logic [22:0] s2_quot_reg;
    logic [9:0]  s2_rem_reg;

    // Output register
    logic        m_valid_reg;
    logic [1:0]  m_kind_reg;
    logic [7:0]  m_cmd_reg;
    logic [15:0] m_seq_reg;
    logic [31:0] m_id_reg;
    logic [3:0]  m_len_reg;
    logic [63:0] m_data_reg;
    logic [22:0] m_sec_reg;
    logic [19:0] m_usec_reg;
    logic        m_match_reg;

    // Move the whole pipeline when the output slot is free
    assign advance = !m_valid_reg || m_ready;
    assign pop     = advance && rec_valid;

    // Classify the record and trim the frame data to its length
    always_comb begin
        kind     = KIND_OTHER;
        id_dec   = 32'd0;
        len_dec  = 4'd0;
        data_dec = 64'd0;
        priority if (rec.command == CMD_RECEIVE_FRAME) begin
            if (rec.dlc > MAX_DATA_BYTES) begin
                kind = KIND_FRAME_ERR;
            end else begin
                kind    = KIND_FRAME;
                id_dec  = rec.frame_id;
                len_dec = rec.dlc[3:0];
                for (int i = 0; i < 8; i++) begin
                    if (8'(i) < rec.dlc) begin
                        data_dec[8*i +: 8] = rec.data[8*i +: 8];
                    end
                end
            end
        end else if (rec.command == CMD_FIRMWARE) begin
            kind     = KIND_FIRMWARE;
            data_dec = {40'd0, rec.stamp[23:0]};
        end else begin
            kind = KIND_OTHER;
        end
    end

    // Split the quotient off and form the remainder
    always_comb begin
        quot     = s1_prod_reg[PROD_W-1:DIV_SHIFT];
        quot_ms  = 32'(quot) * MS_PER_SECOND;
        rem_wide = s1_stamp_reg - quot_ms;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else if (advance) begin
            s1_valid_reg <= rec_valid;
            s2_valid_reg <= s1_valid_reg;
            m_valid_reg  <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            s1_kind_reg  <= kind;
            s1_cmd_reg   <= rec.command;
            s1_seq_reg   <= rec.sequence_no;
            s1_id_reg    <= id_dec;
            s1_len_reg   <= len_dec;
            s1_data_reg  <= data_dec;
            s1_match_reg <= rec.wait_match;
            s1_stamp_reg <= rec.stamp;
            s1_prod_reg  <= PROD_W'(rec.stamp) * PROD_W'(DIV_MAGIC);

            s2_kind_reg  <= s1_kind_reg;
            s2_cmd_reg   <= s1_cmd_reg;
            s2_seq_reg   <= s1_seq_reg;
            s2_id_reg    <= s1_id_reg;
            s2_len_reg   <= s1_len_reg;
            s2_data_reg  <= s1_data_reg;
            s2_match_reg <= s1_match_reg;
            s2_quot_reg  <= quot;
            s2_rem_reg   <= rem_wide[9:0];

            m_kind_reg  <= s2_kind_reg;
            m_cmd_reg   <= s2_cmd_reg;
            m_seq_reg   <= s2_seq_reg;
            m_id_reg    <= s2_id_reg;
            m_len_reg   <= s2_len_reg;
            m_data_reg  <= s2_data_reg;
            m_match_reg <= s2_match_reg;
            // Stamps only for a valid frame
            if (s2_kind_reg == KIND_FRAME) begin
                m_sec_reg  <= s2_quot_reg;
                m_usec_reg <= 20'(s2_rem_reg) * US_PER_MS;
            end else begin
                m_sec_reg  <= 23'd0;
                m_usec_reg <= 20'd0;
            end
        end
    end

    assign m_valid              = m_valid_reg;
    assign m_record_kind        = m_kind_reg;
    assign m_command            = m_cmd_reg;
    assign m_sequence_res       = m_seq_reg;
    assign m_can_id             = m_id_reg;
    assign m_data_length        = m_len_reg;
    assign m_payload            = m_data_reg;
    assign m_stamp_seconds      = m_sec_reg;
    assign m_stamp_microseconds = m_usec_reg;
    assign m_wait_match         = m_match_reg;

`ifndef SYNTHESIS
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_record_kind != KIND_FRAME) |->
        (m_stamp_seconds == 23'd0 && m_stamp_microseconds == 20'd0 && m_can_id == 32'd0))
        else $error("non-frame result carries frame fields");
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data_length <= 4'd8 && m_stamp_microseconds <= 20'd999000))
        else $error("decoded field out of range");
`endif

endmodule

[hdl/spi_tlv_can_response_deframer_core.sv]
// After a record's last byte is accepted, its result passes the queue write, decode and
// multiply, remainder and output registers in that order.
// Throughput: one byte per cycle while the queue has room; the decoder takes one
// record per cycle, so records of four bytes or more stall input only if results stall.
// Reset: synchronous active-low aresetn clears parser position, awaited command and queue.
module spi_tlv_can_response_deframer_core #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    input  logic        s_end_of_transfer,
    input  logic        cfg_write_en,
    input  logic [7:0]  cfg_write_data,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_record_kind,
    output logic [7:0]  m_command,
    output logic [15:0] m_sequence_res,
    output logic [31:0] m_can_id,
    output logic [3:0]  m_data_length,
    output logic [63:0] m_payload,
    output logic [22:0] m_stamp_seconds,
    output logic [19:0] m_stamp_microseconds,
    output logic        m_wait_match
);
    import tlvdf_pkg::*;

    logic byte_accept;
    logic push;
    logic pop;
    logic full;
    logic not_empty;
    rec_t push_rec;
    rec_t head_rec;

    // Accept a byte whenever the queue has room for a record
    assign s_ready     = !full;
    assign byte_accept = s_valid && s_ready;

    tlvdf_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .byte_accept     (byte_accept),
        .rx_byte         (s_rx_byte),
        .end_of_transfer (s_end_of_transfer),
        .cfg_write_en    (cfg_write_en),
        .cfg_write_data  (cfg_write_data),
        .push            (push),
        .push_rec        (push_rec)
    );

    tlvdf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_rec  (push_rec),
        .pop       (pop),
        .full      (full),
        .not_empty (not_empty),
        .head_rec  (head_rec)
    );

    tlvdf_back u_back (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .rec_valid            (not_empty),
        .rec                  (head_rec),
        .pop                  (pop),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_record_kind        (m_record_kind),
        .m_command            (m_command),
        .m_sequence_res       (m_sequence_res),
        .m_can_id             (m_can_id),
        .m_data_length        (m_data_length),
        .m_payload            (m_payload),
        .m_stamp_seconds      (m_stamp_seconds),
        .m_stamp_microseconds (m_stamp_microseconds),
        .m_wait_match         (m_wait_match)
    );

endmodule
